@@ rtl/cs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cs_pkg: shared constants and types of the cosine similarity unit
// Element, sum and datapath widths, and the job record passed from the
// accumulating front to the ratio back end.
// ----------------------------------------------------------------------------
package cs_pkg;

    // element and result widths
    localparam int ELEM_W  = 16;
    localparam int SIM_W   = 16;
    localparam int MAX_LEN = 4096;

    // running sums
    localparam int PROD_W = 2 * ELEM_W;
    localparam int DOT_W  = 44;
    localparam int NORM_W = 43;
    localparam int CNT_W  = $clog2(MAX_LEN + 2);

    // ratio search: quotient bits, odd candidate, wide products
    localparam int Q_W    = SIM_W;
    localparam int ODD_W  = Q_W + 1;
    localparam int SQ_W   = 2 * ODD_W;
    localparam int K_W    = $clog2(Q_W);
    localparam int MAG_W  = DOT_W;
    localparam int P_W    = 2 * NORM_W;
    localparam int MM_W   = 2 * MAG_W;
    localparam int WIDE_W = P_W + SQ_W;
    localparam int MB_W   = MAG_W;

    // job queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // finished sums of one vector pair
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       na;
        logic [NORM_W-1:0]       nb;
        logic                    too_long;
    } t_job;

endpackage
`default_nettype wire

@@ rtl/cs_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cs_ifs: item channels of the cosine similarity unit
// Element pair input channel and similarity result channel, valid/ready.
// ----------------------------------------------------------------------------
interface cs_in_if import cs_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last;

    modport source (output valid, a_elem, b_elem, last, input ready);
    modport sink   (input valid, a_elem, b_elem, last, output ready);
endinterface

interface cs_out_if import cs_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
    logic                    too_long;

    modport source (output valid, similarity, zero_norm, too_long, input ready);
    modport sink   (input valid, similarity, zero_norm, too_long, output ready);
endinterface
`default_nettype wire

@@ rtl/cosine_similarity_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_unit: streaming cosine similarity
// Accumulates element pairs and gives dot/(|a||b|) as signed Q1.15 per vector.
// ----------------------------------------------------------------------------
// The front takes one element pair per cycle while the job queue has room and
// keeps saturating sums; on the last pair the sums go into a two-entry queue
// and the front clears at once. The back end works one vector at a time on a
// bit-serial shift-add multiplier: first the products na*nb and dot^2, with
// nb up to 43 and |dot| up to 44 bits wide, then 16 quotient bits, each from
// one more product of na*nb and an odd candidate square; a vector with a zero
// norm goes straight to its result. Long vectors stream at full rate; short
// ones are paced by this multiplier once the queue fills.
module cosine_similarity_unit import cs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cs_in_if.sink    i_item,
    cs_out_if.source o_res
);

    logic w_push, w_full, w_valid, w_pop;
    t_job w_in_job, w_out_job;

    // accumulating front
    cs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_in_job)
    );

    // job queue
    cs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .o_valid (w_valid),
        .i_pop   (w_pop),
        .o_job   (w_out_job)
    );

    // ratio back end
    cs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_job   (w_out_job),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

@@ rtl/cs_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cs_front: element pair accumulator
// Keeps the saturating dot product, sums of squares and pair count; on the
// last pair hands the finished sums to the job queue and clears.
// ----------------------------------------------------------------------------
module cs_front import cs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cs_in_if.sink  i_item,
    input  logic   i_full,
    output logic   o_push,
    output t_job   o_job
);

    localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [NORM_W-1:0]       N_MAX   = {NORM_W{1'b1}};

    logic signed [DOT_W-1:0] r_dot, n_dot;
    logic [NORM_W-1:0]       r_na, n_na, r_nb, n_nb;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    logic signed [PROD_W-1:0] w_ab, w_aa, w_bb;
    logic signed [DOT_W:0]    w_dsum;
    logic [NORM_W:0]          w_asum, w_bsum;
    logic                     w_acc;

    assign i_item.ready = !i_full;
    assign w_acc        = i_item.valid && !i_full;

    // products of the pair
    assign w_ab = i_item.a_elem * i_item.b_elem;
    assign w_aa = i_item.a_elem * i_item.a_elem;
    assign w_bb = i_item.b_elem * i_item.b_elem;

    // saturating sums
    always_comb begin
        w_dsum = (DOT_W+1)'(r_dot) + (DOT_W+1)'(w_ab);
        if (w_dsum[DOT_W] != w_dsum[DOT_W-1]) begin
            n_dot = w_dsum[DOT_W] ? DOT_MIN : DOT_MAX;
        end else begin
            n_dot = w_dsum[DOT_W-1:0];
        end
        w_asum = {1'b0, r_na} + (NORM_W+1)'($unsigned(w_aa));
        w_bsum = {1'b0, r_nb} + (NORM_W+1)'($unsigned(w_bb));
        n_na   = w_asum[NORM_W] ? N_MAX : w_asum[NORM_W-1:0];
        n_nb   = w_bsum[NORM_W] ? N_MAX : w_bsum[NORM_W-1:0];
        n_cnt  = (r_cnt <= CNT_W'(MAX_LEN)) ? r_cnt + 1'b1 : r_cnt;
    end

    // job to the queue on the last pair
    assign o_push          = w_acc && i_item.last;
    assign o_job.dot       = n_dot;
    assign o_job.na        = n_na;
    assign o_job.nb        = n_nb;
    assign o_job.too_long  = n_cnt > CNT_W'(MAX_LEN);

    // accumulator registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
        end else if (w_acc) begin
            if (i_item.last) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_cnt <= '0;
            end else begin
                r_dot <= n_dot;
                r_na  <= n_na;
                r_nb  <= n_nb;
                r_cnt <= n_cnt;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_cnt == '0 && r_dot == '0 && r_na == '0 && r_nb == '0))
        else $error("sums not cleared after last pair");
`endif

endmodule
`default_nettype wire

@@ rtl/cs_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cs_queue: job queue between front and back
// Small register fifo of finished vector sums.
// ----------------------------------------------------------------------------
module cs_queue import cs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");
`endif

endmodule
`default_nettype wire

@@ rtl/cs_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cs_back: similarity ratio engine
// Forms na*nb and dot^2 on a shift-add multiplier, then finds the rounded
// Q1.15 ratio one quotient bit at a time by comparing odd squares.
// ----------------------------------------------------------------------------
module cs_back import cs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_job     i_job,
    output logic     o_pop,
    cs_out_if.source o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_MP, S_MM, S_SQ, S_ML, S_FIN, S_DONE
    } t_state;

    localparam logic [ODD_W-1:0] Q_LIM = ODD_W'(1) << (SIM_W - 1);

    t_state              r_state, n_state;
    t_job                r_job, n_job;
    logic [WIDE_W-1:0]   r_acc, n_acc, r_ma, n_ma, r_r, n_r;
    logic [MB_W-1:0]     r_mb, n_mb;
    logic [P_W-1:0]      r_p, n_p;
    logic [Q_W-1:0]      r_q, n_q, r_c, n_c;
    logic [K_W-1:0]      r_k, n_k;
    logic signed [SIM_W-1:0] r_sim, n_sim;
    logic                r_ovalid, n_ovalid, r_zn, n_zn, r_tl, n_tl;

    logic [MAG_W-1:0]    w_mag;
    logic [Q_W-1:0]      w_cand;
    logic [ODD_W-1:0]    w_odd, w_qs;
    logic [SQ_W-1:0]     w_sq;
    logic [WIDE_W-1:0]   w_step;

    assign o_res.valid      = r_ovalid;
    assign o_res.similarity = r_sim;
    assign o_res.zero_norm  = r_zn;
    assign o_res.too_long   = r_tl;
    // take a new job only once the result register is free
    assign o_pop            = (r_state == S_IDLE) && i_valid
                              && (!r_ovalid || o_res.ready);

    // magnitude of the dot product and the odd candidate square
    assign w_mag  = r_job.dot[DOT_W-1] ? MAG_W'(-r_job.dot) : MAG_W'(r_job.dot);
    assign w_cand = r_q | (Q_W'(1) << r_k);
    assign w_odd  = {w_cand, 1'b0} - ODD_W'(1);
    assign w_sq   = w_odd * w_odd;
    assign w_qs   = (r_q >= Q_W'(Q_LIM)) ? Q_LIM : {1'b0, r_q};
    assign w_step = r_mb[0] ? r_acc + r_ma : r_acc;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_acc    = r_acc;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_r      = r_r;
        n_p      = r_p;
        n_q      = r_q;
        n_c      = r_c;
        n_k      = r_k;
        n_sim    = r_sim;
        n_zn     = r_zn;
        n_tl     = r_tl;
        n_ovalid = r_ovalid && !o_res.ready;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_job = i_job;
                    n_acc = '0;
                    n_ma  = WIDE_W'(i_job.na);
                    n_mb  = MB_W'(i_job.nb);
                    n_sim = '0;
                    if (i_job.na == '0 || i_job.nb == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MP;
                    end
                end
            end
            S_MP: begin
                if (r_mb == '0) begin
                    n_p     = r_acc[P_W-1:0];
                    n_acc   = '0;
                    n_ma    = WIDE_W'(w_mag);
                    n_mb    = w_mag;
                    n_state = S_MM;
                end else begin
                    n_acc = w_step;
                    n_ma  = r_ma << 1;
                    n_mb  = r_mb >> 1;
                end
            end
            S_MM: begin
                if (r_mb == '0) begin
                    n_r     = {r_acc[MM_W-1:0], {(WIDE_W-MM_W){1'b0}}};
                    n_q     = '0;
                    n_k     = K_W'(Q_W - 1);
                    n_state = S_SQ;
                end else begin
                    n_acc = w_step;
                    n_ma  = r_ma << 1;
                    n_mb  = r_mb >> 1;
                end
            end
            S_SQ: begin
                n_c     = w_cand;
                n_acc   = '0;
                n_ma    = WIDE_W'(r_p);
                n_mb    = MB_W'(w_sq);
                n_state = S_ML;
            end
            S_ML: begin
                if (r_mb == '0) begin
                    if (r_acc <= r_r) begin
                        n_q = r_c;
                    end
                    if (r_k == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = S_SQ;
                    end
                end else begin
                    n_acc = w_step;
                    n_ma  = r_ma << 1;
                    n_mb  = r_mb >> 1;
                end
            end
            S_FIN: begin
                if (r_job.dot[DOT_W-1]) begin
                    n_sim = SIM_W'(-w_qs);
                end else if (w_qs == Q_LIM) begin
                    n_sim = {1'b0, {(SIM_W-1){1'b1}}};
                end else begin
                    n_sim = w_qs[SIM_W-1:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_zn     = (r_job.na == '0) || (r_job.nb == '0);
                    n_tl     = r_job.too_long;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_job <= n_job;
        r_acc <= n_acc;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_r   <= n_r;
        r_p   <= n_p;
        r_q   <= n_q;
        r_c   <= n_c;
        r_k   <= n_k;
        r_sim <= n_sim;
        r_zn  <= n_zn;
        r_tl  <= n_tl;
    end

`ifndef SYNTHESIS
    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.zero_norm |-> o_res.similarity == '0)
        else $error("zero norm item with nonzero similarity");
    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !r_ovalid |=> r_ovalid && r_state == S_IDLE)
        else $error("finished result not registered");
`endif

endmodule
`default_nettype wire
